/* hdl/md5_pkg.sv */
// Shared types and constants for the MD5 stream hasher.
// No dependencies; imported by md5_ctrl, md5_dpath and md5_stream_hasher_unit.
package md5_pkg;

    // Input command codes
    localparam logic CMD_ABSORB = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam logic [7:0] PAD_MARKER  = 8'h80;
    localparam logic [5:0] LEN_POS     = 6'd56;
    localparam logic [5:0] ROUND_LAST  = 6'd63;
    localparam logic [3:0] DIGEST_LAST = 4'd15;

    localparam logic [31:0] CHAIN_INIT [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_AMT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // How the compressed block is built from the buffer
    typedef enum logic [1:0] {
        BLK_DATA,      // full buffer of message bytes
        BLK_PAD,       // data, marker, zeros, length
        BLK_PAD_SPLIT, // data, marker, zeros; length follows in another block
        BLK_LEN_ONLY   // zeros then length
    } blk_mode_t;

    typedef struct packed {
        logic       absorb;
        logic       load_work;
        logic       round_en;
        logic       update_chain;
        logic       init_msg;
        blk_mode_t  mode;
        logic [5:0] round_idx;
        logic [3:0] emit_idx;
    } md5_cmd_t;

    typedef struct packed {
        logic fill_last;  // next byte completes the block
        logic fill_ge56;  // no room for the length after the marker
    } md5_stat_t;

    // Message word index for a round
    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] lo;
        lo = r[3:0];
        case (r[5:4])
            2'd0:    msg_index = lo;
            2'd1:    msg_index = 4'((lo << 2) + lo + 4'd1);
            2'd2:    msg_index = 4'((lo << 1) + lo + 4'd5);
            default: msg_index = 4'((lo << 3) - lo);
        endcase
    endfunction

endpackage

/* hdl/md5_stream_hasher_unit.sv */
// MD5 stream hasher top level: byte-serial RFC 1321 digest, 16 digest bytes per message.
// Absorb: one byte per cycle while s_ready is high; the 64th byte of a block holds s_ready low
// while the single round unit runs the 64 rounds, and then during one chaining update.
// Finish: m_valid rises once the rounds and the chaining update are done, or, when an extra
// padding block is needed, after rounds, update, one reload step, rounds and update; then 16 result
// transactions at one per cycle while m_ready is high; s_ready is low until the last.
// Reset (aresetn, synchronous, active low) restores the MD5 initial chaining words.
module md5_stream_hasher_unit
    import md5_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    // Input channel: one command per transaction
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_cmd,
    input  logic [7:0] s_data_byte,
    // Result channel: digest bytes, words A..D each low byte first
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_digest_byte,
    output logic       m_last
);

    md5_cmd_t  cmd;
    md5_stat_t stat;

    // Controller: sequences absorb, the 64 rounds per block, padding blocks, emission
    md5_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_cmd   (s_cmd),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_last  (m_last),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Datapath: buffer, length counter, chaining words and the round unit.
    // Padding bytes and the length are merged in as words are read for the rounds.
    md5_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_data_byte   (s_data_byte),
        .cmd           (cmd),
        .stat          (stat),
        .m_digest_byte (m_digest_byte)
    );

endmodule

/* hdl/md5_ctrl.sv */
// Sequencer for the MD5 stream hasher: input acceptance, round count, digest emission.
// Depends on md5_pkg.
module md5_ctrl
    import md5_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_cmd,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output logic      m_last,
    input  md5_stat_t stat,
    output md5_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_UPDATE,
        ST_RELOAD,
        ST_EMIT
    } state_t;

    state_t     state_reg;
    blk_mode_t  mode_reg;
    logic [5:0] round_cnt_reg;
    logic [3:0] emit_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mode_reg      <= BLK_DATA;
            round_cnt_reg <= '0;
            emit_cnt_reg  <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    round_cnt_reg <= '0;
                    if (s_valid) begin
                        if (s_cmd == CMD_ABSORB) begin
                            if (stat.fill_last) begin
                                mode_reg  <= BLK_DATA;
                                state_reg <= ST_ROUND;
                            end
                        end else begin
                            mode_reg  <= stat.fill_ge56 ? BLK_PAD_SPLIT : BLK_PAD;
                            state_reg <= ST_ROUND;
                        end
                    end
                end
                ST_ROUND: begin
                    round_cnt_reg <= round_cnt_reg + 6'd1;
                    if (round_cnt_reg == ROUND_LAST) begin
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    emit_cnt_reg <= '0;
                    case (mode_reg)
                        BLK_DATA:      state_reg <= ST_IDLE;
                        BLK_PAD_SPLIT: begin
                            mode_reg  <= BLK_LEN_ONLY;
                            state_reg <= ST_RELOAD;
                        end
                        default:       state_reg <= ST_EMIT;
                    endcase
                end
                ST_RELOAD: begin
                    round_cnt_reg <= '0;
                    state_reg     <= ST_ROUND;
                end
                ST_EMIT: begin
                    if (m_ready) begin
                        emit_cnt_reg <= emit_cnt_reg + 4'd1;
                        if (emit_cnt_reg == DIGEST_LAST) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_EMIT);
    assign m_last  = (emit_cnt_reg == DIGEST_LAST);

    always_comb begin
        cmd              = '0;
        cmd.absorb       = s_ready && s_valid && (s_cmd == CMD_ABSORB);
        cmd.load_work    = (s_ready && s_valid) || (state_reg == ST_RELOAD);
        cmd.round_en     = (state_reg == ST_ROUND);
        cmd.update_chain = (state_reg == ST_UPDATE);
        cmd.init_msg     = m_valid && m_ready && m_last;
        cmd.mode         = mode_reg;
        cmd.round_idx    = round_cnt_reg;
        cmd.emit_idx     = emit_cnt_reg;
    end

endmodule

/* hdl/md5_dpath.sv */
// Datapath for the MD5 stream hasher: block buffer, length, chaining and round unit.
// Depends on md5_pkg; driven by md5_ctrl.
module md5_dpath
    import md5_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] s_data_byte,
    input  md5_cmd_t   cmd,
    output md5_stat_t  stat,
    output logic [7:0] m_digest_byte
);

    logic [31:0] buf_reg [16];
    logic [31:0] chain_reg [4];
    logic [5:0]  fill_reg;
    logic [63:0] bitlen_reg;
    logic [31:0] wa_reg, wb_reg, wc_reg, wd_reg;

    logic [3:0]  g;
    logic [31:0] raw_word;
    logic [31:0] msg_word;
    logic [5:0]  pos [4];
    logic [7:0]  raw_b [4];
    logic [7:0]  len_b [4];
    logic [31:0] f_val;
    logic [31:0] sum;
    logic [63:0] dbl;
    logic [31:0] emit_word;

    assign stat.fill_last = (fill_reg == ROUND_LAST);
    assign stat.fill_ge56 = (fill_reg >= LEN_POS);

    assign g        = msg_index(cmd.round_idx);
    assign raw_word = buf_reg[g];

    // Padding is applied on the read side, so the buffer is never cleared
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            pos[k]   = {g, 2'(k)};
            raw_b[k] = raw_word[8*k +: 8];
            len_b[k] = bitlen_reg[8*pos[k][2:0] +: 8];
            case (cmd.mode)
                BLK_DATA: msg_word[8*k +: 8] = raw_b[k];
                BLK_PAD: begin
                    if (pos[k] < fill_reg)       msg_word[8*k +: 8] = raw_b[k];
                    else if (pos[k] == fill_reg) msg_word[8*k +: 8] = PAD_MARKER;
                    else if (pos[k] >= LEN_POS)  msg_word[8*k +: 8] = len_b[k];
                    else                         msg_word[8*k +: 8] = 8'h00;
                end
                BLK_PAD_SPLIT: begin
                    if (pos[k] < fill_reg)       msg_word[8*k +: 8] = raw_b[k];
                    else if (pos[k] == fill_reg) msg_word[8*k +: 8] = PAD_MARKER;
                    else                         msg_word[8*k +: 8] = 8'h00;
                end
                default: begin
                    if (pos[k] >= LEN_POS)       msg_word[8*k +: 8] = len_b[k];
                    else                         msg_word[8*k +: 8] = 8'h00;
                end
            endcase
        end
    end

    always_comb begin
        case (cmd.round_idx[5:4])
            2'd0:    f_val = (wb_reg & wc_reg) | (~wb_reg & wd_reg);
            2'd1:    f_val = (wb_reg & wd_reg) | (wc_reg & ~wd_reg);
            2'd2:    f_val = wb_reg ^ wc_reg ^ wd_reg;
            default: f_val = wc_reg ^ (wb_reg | ~wd_reg);
        endcase
        sum = wa_reg + f_val + ROUND_K[cmd.round_idx] + msg_word;
        dbl = {sum, sum} << ROT_AMT[{cmd.round_idx[5:4], cmd.round_idx[1:0]}];
    end

    // Message buffer: one byte lane written per absorbed byte
    always_ff @(posedge aclk) begin
        if (cmd.absorb) begin
            buf_reg[fill_reg[5:2]][8*fill_reg[1:0] +: 8] <= s_data_byte;
        end
    end

    // Working variables
    always_ff @(posedge aclk) begin
        if (cmd.load_work) begin
            wa_reg <= chain_reg[0];
            wb_reg <= chain_reg[1];
            wc_reg <= chain_reg[2];
            wd_reg <= chain_reg[3];
        end else if (cmd.round_en) begin
            wa_reg <= wd_reg;
            wd_reg <= wc_reg;
            wc_reg <= wb_reg;
            wb_reg <= wb_reg + dbl[63:32];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.init_msg) begin
            for (int i = 0; i < 4; i++) begin
                chain_reg[i] <= CHAIN_INIT[i];
            end
            fill_reg   <= '0;
            bitlen_reg <= '0;
        end else begin
            if (cmd.absorb) begin
                fill_reg   <= fill_reg + 6'd1;
                bitlen_reg <= bitlen_reg + 64'd8;
            end
            if (cmd.update_chain) begin
                chain_reg[0] <= chain_reg[0] + wa_reg;
                chain_reg[1] <= chain_reg[1] + wb_reg;
                chain_reg[2] <= chain_reg[2] + wc_reg;
                chain_reg[3] <= chain_reg[3] + wd_reg;
            end
        end
    end

    assign emit_word     = chain_reg[cmd.emit_idx[3:2]];
    assign m_digest_byte = emit_word[8*cmd.emit_idx[1:0] +: 8];

endmodule
